/* rtl/erp_pkg.sv */
// Shared types, constants and the matrix build program for the Euler point rotator.
package erp_pkg;

  localparam int COORD_BITS = 24;
  localparam int TRIG_BITS  = 16;
  localparam int FRAC_BITS  = TRIG_BITS - 1;
  localparam int OPW        = TRIG_BITS + 1;
  localparam int NUM_REGS   = 6;
  localparam int IDX_BITS   = 3;
  localparam int MAT_N      = 9;
  localparam int NUM_STEPS  = 17;
  localparam int STEP_BITS  = $clog2(NUM_STEPS);

  // Configuration register indexes, also used as operand selects.
  localparam logic [IDX_BITS-1:0] REG_SIN_A = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_COS_A = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_SIN_B = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_COS_B = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_SIN_G = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_COS_G = 3'd5;
  localparam logic [IDX_BITS-1:0] SRC_PROD  = 3'd6;

  // Accumulator actions on the product of the previous step.
  localparam logic [2:0] ACC_NOP    = 3'd0;
  localparam logic [2:0] ACC_LOAD   = 3'd1;
  localparam logic [2:0] ACC_WR_ADD = 3'd2;
  localparam logic [2:0] ACC_WR_SUB = 3'd3;
  localparam logic [2:0] ACC_WR_ONE = 3'd4;

  typedef logic signed [TRIG_BITS-1:0]  trig_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef trig_t  [MAT_N-1:0] mat_t;
  typedef trig_t  [2:0]       row_t;
  typedef coord_t [2:0]       vec_t;

  typedef struct packed {
    coord_t     pos_x;
    coord_t     pos_y;
    coord_t     pos_z;
    logic [7:0] atom_kind;
    logic       last_point;
  } in_item_t;

  typedef struct packed {
    coord_t     rot_x;
    coord_t     rot_y;
    coord_t     rot_z;
    logic [7:0] kind_out;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] a_sel;
    logic                a_neg;
    logic [IDX_BITS-1:0] b_sel;
    logic [2:0]          acc_op;
    logic [2:0]          wr_idx;
  } step_t;

  function automatic step_t mk_step(input logic [IDX_BITS-1:0] a, input logic neg,
                                    input logic [IDX_BITS-1:0] b, input logic [2:0] op,
                                    input logic [2:0] idx);
    step_t r;
    r.a_sel  = a;
    r.a_neg  = neg;
    r.b_sel  = b;
    r.acc_op = op;
    r.wr_idx = idx;
    return r;
  endfunction

  // One multiply per step; the accumulator acts on the previous step's product.
  function automatic step_t step_rom(input logic [STEP_BITS-1:0] s);
    step_t r;
    case (s)
      0:  r = mk_step(REG_COS_A, 1'b0, REG_COS_G, ACC_NOP,    3'd0);
      1:  r = mk_step(REG_SIN_G, 1'b0, REG_SIN_A, ACC_LOAD,   3'd0);
      2:  r = mk_step(REG_COS_B, 1'b0, SRC_PROD,  ACC_NOP,    3'd0);
      3:  r = mk_step(REG_COS_A, 1'b0, REG_SIN_G, ACC_WR_SUB, 3'd0);
      4:  r = mk_step(REG_SIN_A, 1'b0, REG_COS_B, ACC_LOAD,   3'd0);
      5:  r = mk_step(REG_COS_G, 1'b0, SRC_PROD,  ACC_NOP,    3'd0);
      6:  r = mk_step(REG_SIN_A, 1'b0, REG_SIN_B, ACC_WR_ADD, 3'd1);
      7:  r = mk_step(REG_SIN_A, 1'b1, REG_COS_G, ACC_WR_ONE, 3'd2);
      8:  r = mk_step(REG_COS_A, 1'b0, REG_COS_B, ACC_LOAD,   3'd0);
      9:  r = mk_step(REG_SIN_G, 1'b0, SRC_PROD,  ACC_NOP,    3'd0);
      10: r = mk_step(REG_SIN_A, 1'b1, REG_SIN_G, ACC_WR_SUB, 3'd3);
      11: r = mk_step(REG_COS_A, 1'b0, REG_COS_B, ACC_LOAD,   3'd0);
      12: r = mk_step(REG_COS_G, 1'b0, SRC_PROD,  ACC_NOP,    3'd0);
      13: r = mk_step(REG_COS_A, 1'b0, REG_SIN_B, ACC_WR_ADD, 3'd4);
      14: r = mk_step(REG_SIN_G, 1'b0, REG_SIN_B, ACC_WR_ONE, 3'd5);
      15: r = mk_step(REG_SIN_B, 1'b1, REG_COS_G, ACC_WR_ONE, 3'd6);
      16: r = mk_step(REG_SIN_A, 1'b0, REG_SIN_A, ACC_WR_ONE, 3'd7);
      default: r = mk_step(REG_SIN_A, 1'b0, REG_SIN_A, ACC_NOP, 3'd0);
    endcase
    return r;
  endfunction

  // Clamp a sum of two products to a signed trig value.
  function automatic trig_t sat_trig(input logic signed [TRIG_BITS+1:0] v);
    logic signed [TRIG_BITS+1:0] hi;
    logic signed [TRIG_BITS+1:0] lo;
    hi = {3'b000, {(TRIG_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[TRIG_BITS-1:0];
    end else if (v < lo) begin
      return lo[TRIG_BITS-1:0];
    end
    return v[TRIG_BITS-1:0];
  endfunction

endpackage

/* rtl/erp_build.sv */
// Configuration registers and the sequencer that rebuilds the rotation matrix.
module erp_build import erp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_idx,
  input  logic [TRIG_BITS-1:0] cfg_wdata,
  output logic                busy,
  output mat_t                mat
);

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(NUM_STEPS - 1);
  localparam trig_t TRIG_ONE = {1'b0, {FRAC_BITS{1'b1}}};

  trig_t sin_a_r, cos_a_r, sin_b_r, cos_b_r, sin_g_r, cos_g_r;
  logic                 busy_r;
  logic [STEP_BITS-1:0] step_r;
  logic signed [OPW-1:0] prod_r, acc_r;
  trig_t mat_r [8];

  step_t st;
  trig_t a_raw, b_raw;
  logic signed [OPW-1:0]   a_ext, op_a, op_b, prod_nxt;
  logic signed [2*OPW-1:0] mul_full, mul_sh;
  logic signed [OPW:0]     ent_nxt;
  logic                    cfg_hit, ent_wr;

  assign cfg_hit = cfg_we && (cfg_idx < IDX_BITS'(NUM_REGS));
  assign st      = step_rom(step_r);

  always_comb begin
    case (st.a_sel)
      REG_SIN_A: a_raw = sin_a_r;
      REG_COS_A: a_raw = cos_a_r;
      REG_SIN_B: a_raw = sin_b_r;
      REG_COS_B: a_raw = cos_b_r;
      REG_SIN_G: a_raw = sin_g_r;
      REG_COS_G: a_raw = cos_g_r;
      default:   a_raw = '0;
    endcase
    case (st.b_sel)
      REG_SIN_A: b_raw = sin_a_r;
      REG_COS_A: b_raw = cos_a_r;
      REG_SIN_B: b_raw = sin_b_r;
      REG_COS_B: b_raw = cos_b_r;
      REG_SIN_G: b_raw = sin_g_r;
      REG_COS_G: b_raw = cos_g_r;
      default:   b_raw = '0;
    endcase
  end

  // Negate before the product so the floor matches a leading minus sign.
  assign a_ext    = {a_raw[TRIG_BITS-1], a_raw};
  assign op_a     = st.a_neg ? -a_ext : a_ext;
  assign op_b     = (st.b_sel == SRC_PROD) ? prod_r : {b_raw[TRIG_BITS-1], b_raw};
  assign mul_full = op_a * op_b;
  assign mul_sh   = mul_full >>> FRAC_BITS;
  assign prod_nxt = mul_sh[OPW-1:0];

  always_comb begin
    ent_wr = 1'b1;
    case (st.acc_op)
      ACC_WR_ADD: ent_nxt = {acc_r[OPW-1], acc_r} + {prod_r[OPW-1], prod_r};
      ACC_WR_SUB: ent_nxt = {acc_r[OPW-1], acc_r} - {prod_r[OPW-1], prod_r};
      ACC_WR_ONE: ent_nxt = {prod_r[OPW-1], prod_r};
      default: begin
        ent_nxt = '0;
        ent_wr  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_a_r <= '0;
      cos_a_r <= TRIG_ONE;
      sin_b_r <= '0;
      cos_b_r <= TRIG_ONE;
      sin_g_r <= '0;
      cos_g_r <= TRIG_ONE;
      busy_r  <= 1'b1;
      step_r  <= '0;
    end else if (cfg_hit) begin
      case (cfg_idx)
        REG_SIN_A: sin_a_r <= cfg_wdata;
        REG_COS_A: cos_a_r <= cfg_wdata;
        REG_SIN_B: sin_b_r <= cfg_wdata;
        REG_COS_B: cos_b_r <= cfg_wdata;
        REG_SIN_G: sin_g_r <= cfg_wdata;
        REG_COS_G: cos_g_r <= cfg_wdata;
        default: ;
      endcase
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      prod_r <= prod_nxt;
      if (st.acc_op == ACC_LOAD) begin
        acc_r <= prod_r;
      end
      if (ent_wr) begin
        mat_r[st.wr_idx] <= sat_trig(ent_nxt);
      end
    end
  end

  assign busy = busy_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mat[i] = mat_r[i];
    end
    mat[8] = cos_b_r;
  end

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> busy_r && (step_r == '0))
    else $error("valid config write did not restart the matrix build");

  a_build_ends: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (step_r == LAST_STEP) && !cfg_hit |=> !busy_r)
    else $error("matrix build did not finish after its last step");

endmodule

/* rtl/erp_lane.sv */
// One output coordinate: registered products of a matrix row, then sum, round and clamp.
module erp_lane import erp_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  row_t   row,
  input  vec_t   pos,
  output coord_t coord
);

  localparam int PW = COORD_BITS + TRIG_BITS;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod_r [3];
  logic signed [SW-1:0] sum, sh, hi, lo;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= $signed(row[k]) * $signed(pos[k]);
      end
    end
  end

  assign hi  = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  assign lo  = ~hi;
  assign sum = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2])
             + (SW'(1) <<< (FRAC_BITS - 1));
  assign sh  = sum >>> FRAC_BITS;

  always_comb begin
    if (sh > hi) begin
      coord = hi[COORD_BITS-1:0];
    end else if (sh < lo) begin
      coord = lo[COORD_BITS-1:0];
    end else begin
      coord = sh[COORD_BITS-1:0];
    end
  end

endmodule

/* rtl/euler_rotation_of_points.sv */
// Top level of the Euler z-x-z point rotator: config, three lanes and the output register.
//
// Usage:
//   Software writes the sines and cosines of the three Euler angles (Q1.15) through
//   cfg_we / cfg_idx / cfg_wdata, one register per cycle, while no transaction is in
//   flight. Indexes 0..5 are sin/cos of alpha, beta, gamma; other indexes are ignored.
//   Each valid write restarts the matrix build on one shared multiplier; in_ready stays
//   low until it finishes. Reset also loads the near-identity angles and runs the same
//   build before the first point is taken.
//   Points enter on in_valid/in_ready as in_data; each transaction yields exactly one
//   result on out_valid/out_ready as out_data (R times the point, rounded half up and
//   clamped to 24 bits, with atom kind and last marker passed along).
//   Path: an accepted point is registered in the product stage, then summed, rounded
//   and clamped into the output register.
//   Throughput: one point per cycle unless out_ready stalls or a build runs; three
//   lanes each hold one 24x16 multiplier per matrix column, and the output register
//   merges the lanes. Stall: when out_ready is low, the output register holds and
//   the product stage keeps one more point; in_ready drops once both are full.
module euler_rotation_of_points import erp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [IDX_BITS-1:0]  cfg_idx,
  input  logic [TRIG_BITS-1:0] cfg_wdata
);

  logic      bld_busy;
  mat_t      mat;
  vec_t      pos;
  row_t      row  [3];
  coord_t    lane_out [3];

  // Product stage control and sideband.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_kind_r;
  logic       s1_last_r;
  logic       s1_adv, s1_load;

  // Output (merge) register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      out_load;

  erp_build u_build (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .busy      (bld_busy),
    .mat       (mat)
  );

  assign pos[0] = in_data.pos_x;
  assign pos[1] = in_data.pos_y;
  assign pos[2] = in_data.pos_z;

  // One lane per output coordinate; lane d uses row d of the matrix.
  for (genvar d = 0; d < 3; d++) begin : g_lane
    for (genvar k = 0; k < 3; k++) begin : g_col
      assign row[d][k] = mat[3*d + k];
    end
    erp_lane u_lane (
      .clk   (clk),
      .en    (s1_load),
      .row   (row[d]),
      .pos   (pos),
      .coord (lane_out[d])
    );
  end

  // Advance the output register when it is empty or being drained.
  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  // Product stage frees up when empty or when its point moves on.
  assign s1_adv   = !s1_valid_r || out_load;
  assign in_ready = s1_adv && !bld_busy;
  assign s1_load  = in_valid && in_ready;

  assign s1_valid_nxt  = s1_adv ? s1_load : s1_valid_r;
  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind_r <= in_data.atom_kind;
      s1_last_r <= in_data.last_point;
    end
    if (out_load) begin
      out_data_r.rot_x    <= lane_out[0];
      out_data_r.rot_y    <= lane_out[1];
      out_data_r.rot_z    <= lane_out[2];
      out_data_r.kind_out <= s1_kind_r;
      out_data_r.last_out <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |=> s1_valid_r)
    else $error("accepted transaction missing from product stage");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a point in the product stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_load |=> s1_valid_r && $stable(s1_kind_r) && $stable(s1_last_r))
    else $error("stalled product stage lost or changed its point");

endmodule

/* verif/euler_rotation_of_points_tb.sv */
// Self-checking testbench for the Euler z-x-z point rotator.
`timescale 1ns / 100ps

module testbench;
  import erp_pkg::*;

  // Transaction-free stretch that ends the run as hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIR_N          = 38;
  localparam int RAND_PHASES    = 14;
  localparam int PHASE_ITEMS    = 100;

  // Indexes past the last register; writes there must be dropped.
  localparam logic [IDX_BITS-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [IDX_BITS-1:0] IDX_SPARE_B = 3'd7;

  // Ways of picking the angle registers for a random phase.
  localparam int CFG_RANDOM  = 0;
  localparam int CFG_EXTREME = 1;
  localparam int CFG_PARTIAL = 2;

  localparam coord_t CMAX = 24'h7FFFFF;
  localparam coord_t CMIN = 24'h800000;
  localparam coord_t C0   = 24'h000000;

  typedef enum logic [0:0] {ROW_CFG, ROW_PT} row_op_t;

  // One row of the directed part: a register write or a point, with an
  // optional hand-typed expectation for the three coordinates.
  typedef struct packed {
    row_op_t             op;
    logic [IDX_BITS-1:0] idx;
    trig_t               val;
    in_item_t            pt;
    logic                typed;
    coord_t              ex;
    coord_t              ey;
    coord_t              ez;
  } stim_row_t;

  localparam in_item_t NO_PT = '0;

  localparam stim_row_t DIR_TAB [DIR_N] = '{
    // Reset matrix (near identity).
    '{ROW_PT,  3'd0, 16'h0000, '{C0, C0, C0, 8'h00, 1'b0}, 1'b1, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{24'sd1, C0, C0, 8'h01, 1'b0}, 1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{CMAX, CMAX, CMAX, 8'hFF, 1'b1}, 1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{CMIN, CMIN, CMIN, 8'h00, 1'b1}, 1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{CMAX, CMIN, 24'sd1, 8'h80, 1'b0}, 1'b0, C0, C0, C0},
    // Writes past the last register leave the matrix alone.
    '{ROW_CFG, IDX_SPARE_A, 16'h8000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, IDX_SPARE_B, 16'h1234, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{CMAX, C0, CMIN, 8'h55, 1'b0}, 1'b0, C0, C0, C0},
    // All zero angles: zero matrix, every point maps to the origin.
    '{ROW_CFG, REG_SIN_A, 16'h0000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_COS_A, 16'h0000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_SIN_B, 16'h0000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_COS_B, 16'h0000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_SIN_G, 16'h0000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_COS_G, 16'h0000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{CMAX, CMAX, CMAX, 8'hAA, 1'b1}, 1'b1, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{CMIN, CMIN, CMIN, 8'h55, 1'b0}, 1'b1, C0, C0, C0},
    // Most negative everywhere: entries and outputs saturate.
    '{ROW_CFG, REG_SIN_A, 16'h8000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_COS_A, 16'h8000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_SIN_B, 16'h8000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_COS_B, 16'h8000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_SIN_G, 16'h8000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_COS_G, 16'h8000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{CMAX, CMAX, CMAX, 8'h0F, 1'b0}, 1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{CMIN, CMAX, CMIN, 8'hF0, 1'b1}, 1'b0, C0, C0, C0},
    // Most positive everywhere.
    '{ROW_CFG, REG_SIN_A, 16'h7FFF, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_COS_A, 16'h7FFF, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_SIN_B, 16'h7FFF, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_COS_B, 16'h7FFF, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_SIN_G, 16'h7FFF, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_COS_G, 16'h7FFF, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{CMIN, CMIN, CMIN, 8'h01, 1'b0}, 1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{24'sd1, -24'sd1, 24'sd1, 8'h02, 1'b1}, 1'b0, C0, C0, C0},
    // Quarter turn about z in the first rotation, the others at zero.
    '{ROW_CFG, REG_SIN_A, 16'h7FFF, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_COS_A, 16'h0000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_SIN_B, 16'h0000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_CFG, REG_SIN_G, 16'h0000, NO_PT, 1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{24'sd1000, -24'sd2000, 24'sd3000, 8'h06, 1'b0},
      1'b0, C0, C0, C0},
    '{ROW_PT,  3'd0, 16'h0000, '{CMAX, C0, C0, 8'h07, 1'b1}, 1'b0, C0, C0, C0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [IDX_BITS-1:0]  cfg_idx;
  logic [TRIG_BITS-1:0] cfg_wdata;

  // Shadow of the angle registers and the matrix built from them.
  trig_t     angle_reg [NUM_REGS];
  longint    rot_mat   [MAT_N];
  // Rotated points still owed by the block, oldest first.
  out_item_t pending_rot [$];
  int        mismatch_cnt = 0;
  int        quiet_cycles = 0;
  // Set per phase: the side runs back to back with no idling.
  logic      tx_quiet = 1'b0;
  logic      rx_quiet = 1'b0;

  string     fld_name [5] = '{"rot_x", "rot_y", "rot_z", "kind_out", "last_out"};

  euler_rotation_of_points i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Q1.15 product, floored (arithmetic shift of a signed value).
  function automatic longint fmul(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // Rebuild the z-x-z matrix from the shadow registers. A leading minus
  // goes on the first factor before flooring; triple products floor twice.
  function automatic void rebuild_rotation();
    longint sa, ca, sb, cb, sg, cg;
    longint m [MAT_N];
    sa = angle_reg[REG_SIN_A];
    ca = angle_reg[REG_COS_A];
    sb = angle_reg[REG_SIN_B];
    cb = angle_reg[REG_COS_B];
    sg = angle_reg[REG_SIN_G];
    cg = angle_reg[REG_COS_G];
    m[0] = fmul(ca, cg) - fmul(fmul(sg, sa), cb);
    m[1] = fmul(ca, sg) + fmul(fmul(sa, cb), cg);
    m[2] = fmul(sa, sb);
    m[3] = fmul(-sa, cg) - fmul(fmul(ca, cb), sg);
    m[4] = fmul(-sa, sg) + fmul(fmul(ca, cb), cg);
    m[5] = fmul(ca, sb);
    m[6] = fmul(sg, sb);
    m[7] = fmul(-sb, cg);
    m[8] = cb;
    for (int i = 0; i < MAT_N; i++) begin
      rot_mat[i] = clamp(m[i], TRIG_BITS);
    end
  endfunction

  // R times the point, rounded half up at the binary point, clamped.
  function automatic out_item_t rotate_point(input in_item_t pt);
    longint    pv  [3];
    longint    res [3];
    longint    acc;
    out_item_t o;
    pv[0] = pt.pos_x;
    pv[1] = pt.pos_y;
    pv[2] = pt.pos_z;
    for (int d = 0; d < 3; d++) begin
      acc = longint'(1) <<< (FRAC_BITS - 1);
      for (int k = 0; k < 3; k++) begin
        acc += rot_mat[d * 3 + k] * pv[k];
      end
      res[d] = clamp(acc >>> FRAC_BITS, COORD_BITS);
    end
    o.rot_x    = coord_t'(res[0]);
    o.rot_y    = coord_t'(res[1]);
    o.rot_z    = coord_t'(res[2]);
    o.kind_out = pt.atom_kind;
    o.last_out = pt.last_point;
    return o;
  endfunction

  // Drop valid and hold until every owed result has been taken.
  task automatic drain_points();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (pending_rot.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Drive one register write; mirror it in the shadow copy.
  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input trig_t val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx < NUM_REGS) begin
      angle_reg[idx] = val;
      rebuild_rotation();
    end
    @(negedge clk);
  endtask

  // Offer one point after a random gap and hold it until the transaction
  // completes. Valid is only lowered when a gap follows, so back-to-back
  // points keep it high.
  task automatic send_point(input in_item_t pt, input logic typed,
                            input out_item_t typed_exp);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    // Predict with the matrix in force when the point went in.
    pending_rot.push_back(typed ? typed_exp : rotate_point(pt));
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return CMAX;
      1:       return CMIN;
      2, 3:    return coord_t'(int'($urandom_range(0, 4095)) - 2048);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Result side: stall a random number of cycles per result, then take it.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) begin
        @(posedge clk);
      end
      @(negedge clk);
    end
  end

  // Compare every accepted result against the oldest prediction.
  always @(posedge clk) begin : check_rot
    out_item_t want;
    longint    want_f [5];
    longint    got_f  [5];
    if (rst_n && out_valid && out_ready) begin
      got_f = '{longint'(out_data.rot_x), longint'(out_data.rot_y),
                longint'(out_data.rot_z), longint'(out_data.kind_out),
                longint'(out_data.last_out)};
      if (pending_rot.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d %0d %0d %0d %0d",
                 $time, got_f[0], got_f[1], got_f[2], got_f[3], got_f[4]);
        mismatch_cnt++;
      end else begin
        want = pending_rot.pop_front();
        want_f = '{longint'(want.rot_x), longint'(want.rot_y), longint'(want.rot_z),
                   longint'(want.kind_out), longint'(want.last_out)};
        for (int f = 0; f < 5; f++) begin
          if (want_f[f] != got_f[f]) begin
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, fld_name[f], want_f[f], got_f[f]);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    in_item_t  pt;
    out_item_t texp;
    int        mode;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;

    // Reset state of the angle registers: sines zero, cosines at max.
    angle_reg[REG_SIN_A] = 16'h0000;
    angle_reg[REG_COS_A] = 16'h7FFF;
    angle_reg[REG_SIN_B] = 16'h0000;
    angle_reg[REG_COS_B] = 16'h7FFF;
    angle_reg[REG_SIN_G] = 16'h0000;
    angle_reg[REG_COS_G] = 16'h7FFF;
    rebuild_rotation();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Register writes only go out once the block is idle.
    for (int r = 0; r < DIR_N; r++) begin
      row = DIR_TAB[r];
      if (row.op == ROW_CFG) begin
        drain_points();
        write_reg(row.idx, row.val);
      end else begin
        texp = '{row.ex, row.ey, row.ez, row.pt.atom_kind, row.pt.last_point};
        send_point(row.pt, row.typed, texp);
      end
    end

    // Random part: each phase picks new angles, idling styles and points.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_points();
      // First phase runs both sides flat out, later ones are drawn.
      tx_quiet = (ph == 0) || ($urandom_range(0, 3) == 0);
      rx_quiet = (ph == 0) || ($urandom_range(0, 3) == 0);
      mode = $urandom_range(CFG_RANDOM, CFG_PARTIAL);
      for (int i = 0; i < NUM_REGS; i++) begin
        if (mode == CFG_PARTIAL && $urandom_range(0, 1) == 0) begin
          continue;
        end
        if (mode == CFG_EXTREME) begin
          case ($urandom_range(0, 3))
            0:       write_reg(i[IDX_BITS-1:0], 16'h8000);
            1:       write_reg(i[IDX_BITS-1:0], 16'h7FFF);
            2:       write_reg(i[IDX_BITS-1:0], 16'h0000);
            default: write_reg(i[IDX_BITS-1:0], trig_t'($urandom));
          endcase
        end else begin
          write_reg(i[IDX_BITS-1:0], trig_t'($urandom));
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, trig_t'($urandom));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Now and then hold off until the pipeline is empty.
        if ($urandom_range(0, 63) == 0) begin
          drain_points();
        end
        pt.pos_x      = rand_coord();
        pt.pos_y      = rand_coord();
        pt.pos_z      = rand_coord();
        pt.atom_kind  = 8'($urandom_range(0, 255));
        pt.last_point = ($urandom_range(0, 7) == 0);
        send_point(pt, 1'b0, '0);
      end
    end

    drain_points();
    // Give the two-stage pipeline time to show any stray result.
    repeat (8) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
